>>> sv/pwm_timer_channel_unit_assert.svh
// ----------------------------------------------------------------------------
// PWM timer channel assertion macros
// Shared property forms for the checkers of the timer channel unit.
// ----------------------------------------------------------------------------
`ifndef PWM_TIMER_CHANNEL_UNIT_ASSERT_SVH
`define PWM_TIMER_CHANNEL_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk and quiet during reset
`define PTC_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and quiet during reset
`define PTC_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/ptc_pkg.sv
// ----------------------------------------------------------------------------
// PWM timer channel package
// Widths, request and register codes, field positions and item types.
// ----------------------------------------------------------------------------
package ptc_pkg;

	localparam int unsigned COUNT_WIDTH = 16;
	localparam int unsigned CNT_W       = COUNT_WIDTH;
	localparam int unsigned PSC_W       = 16;
	localparam int unsigned DATA_W      = 16;
	localparam int unsigned DUTY_W      = 8;
	localparam int unsigned PCT_W       = 7;
	localparam int unsigned MODE_W      = 3;

	localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

	// (reload + 1) * pct, and the reciprocal of 100 used to divide it
	localparam int unsigned PROD_W      = CNT_W + 1 + PCT_W;
	localparam int unsigned RECIP_SHIFT = PROD_W + PCT_W;
	localparam int unsigned RECIP_W     = RECIP_SHIFT - 6;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((64'd1 << RECIP_SHIFT) / 64'd100) + 64'd1);
	localparam int unsigned QP_W        = PROD_W + RECIP_W;

	// Request codes
	localparam logic [1:0] REQ_TICK  = 2'd0;
	localparam logic [1:0] REQ_WRITE = 2'd1;
	localparam logic [1:0] REQ_READ  = 2'd2;
	localparam logic [1:0] REQ_DUTY  = 2'd3;

	// Register select codes
	localparam logic [2:0] REG_CTRL    = 3'd0;
	localparam logic [2:0] REG_MODE    = 3'd1;
	localparam logic [2:0] REG_ENABLE  = 3'd2;
	localparam logic [2:0] REG_EVENT   = 3'd3;
	localparam logic [2:0] REG_PRESC   = 3'd4;
	localparam logic [2:0] REG_RELOAD  = 3'd5;
	localparam logic [2:0] REG_COMPARE = 3'd6;
	localparam logic [2:0] REG_COUNTER = 3'd7;

	// Bit positions inside the control registers
	localparam int unsigned CTRL_RUN_BIT  = 0;
	localparam int unsigned CTRL_RBUF_BIT = 7;
	localparam int unsigned MODE_LSB      = 4;
	localparam int unsigned MODE_CBUF_BIT = 3;
	localparam int unsigned EN_ON_BIT     = 0;
	localparam int unsigned EN_POL_BIT    = 1;
	localparam int unsigned EVT_UPD_BIT   = 0;

	localparam logic [MODE_W-1:0] MODE_PWM1 = 3'd6;

	typedef struct packed {
		logic [1:0]        req_type;
		logic [2:0]        reg_sel;
		logic [DATA_W-1:0] write_data;
		logic [PROD_W-1:0] duty_prod;
	} item_t;

	typedef struct packed {
		logic              pwm_level;
		logic [DATA_W-1:0] read_data;
		logic              update_event;
	} result_t;

endpackage

>>> sv/ptc_core.sv
// ----------------------------------------------------------------------------
// PWM timer channel core
// Timer state, single-pass next-state logic for one transaction and the
// channel output it leaves behind.
// ----------------------------------------------------------------------------
module ptc_core import ptc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             exec,
	input  item_t            item,
	output result_t          result,
	output logic [CNT_W-1:0] reload_next
);

	logic [PSC_W-1:0]  psc_cnt_q, psc_cnt_n;
	logic [CNT_W-1:0]  main_cnt_q, main_cnt_n;
	logic [PSC_W-1:0]  psc_lim_q, psc_lim_n;
	logic [CNT_W-1:0]  rld_pre_q, rld_pre_n;
	logic [CNT_W-1:0]  rld_act_q, rld_act_n;
	logic [CNT_W-1:0]  cmp_pre_q, cmp_pre_n;
	logic [CNT_W-1:0]  cmp_act_q, cmp_act_n;
	logic              run_q, run_n;
	logic              rld_buf_q, rld_buf_n;
	logic [MODE_W-1:0] mode_q, mode_n;
	logic              cmp_buf_q, cmp_buf_n;
	logic              pol_q, pol_n;
	logic              on_q, on_n;

	logic [QP_W-1:0]   quot_prod;
	logic [CNT_W-1:0]  duty_cmp;
	logic [CNT_W-1:0]  wr_cnt;
	logic [DATA_W-1:0] rd_data;
	logic              upd;
	logic              ref_level;

	// Divide by 100 through the reciprocal; exact over the product's range
	assign quot_prod = QP_W'(item.duty_prod) * QP_W'(RECIP);
	assign duty_cmp  = CNT_W'(quot_prod >> RECIP_SHIFT);
	assign wr_cnt    = CNT_W'(item.write_data);

	always_comb begin
		psc_cnt_n  = psc_cnt_q;
		main_cnt_n = main_cnt_q;
		psc_lim_n  = psc_lim_q;
		rld_pre_n  = rld_pre_q;
		rld_act_n  = rld_act_q;
		cmp_pre_n  = cmp_pre_q;
		cmp_act_n  = cmp_act_q;
		run_n      = run_q;
		rld_buf_n  = rld_buf_q;
		mode_n     = mode_q;
		cmp_buf_n  = cmp_buf_q;
		pol_n      = pol_q;
		on_n       = on_q;
		rd_data    = '0;
		upd        = 1'b0;
		unique case (item.req_type)
			REQ_TICK: begin
				if (run_q) begin
					if (psc_cnt_q < psc_lim_q) begin
						psc_cnt_n = psc_cnt_q + PSC_W'(1);
					end else begin
						psc_cnt_n = '0;
						if (main_cnt_q >= rld_act_q) begin
							main_cnt_n = '0;
							rld_act_n  = rld_pre_q;
							cmp_act_n  = cmp_pre_q;
							upd        = 1'b1;
						end else begin
							main_cnt_n = main_cnt_q + CNT_W'(1);
						end
					end
				end
			end
			REQ_WRITE: begin
				unique case (item.reg_sel)
					REG_CTRL: begin
						run_n     = item.write_data[CTRL_RUN_BIT];
						rld_buf_n = item.write_data[CTRL_RBUF_BIT];
					end
					REG_MODE: begin
						mode_n    = item.write_data[MODE_LSB +: MODE_W];
						cmp_buf_n = item.write_data[MODE_CBUF_BIT];
					end
					REG_ENABLE: begin
						on_n  = item.write_data[EN_ON_BIT];
						pol_n = item.write_data[EN_POL_BIT];
					end
					REG_EVENT: begin
						if (item.write_data[EVT_UPD_BIT]) begin
							psc_cnt_n  = '0;
							main_cnt_n = '0;
							rld_act_n  = rld_pre_q;
							cmp_act_n  = cmp_pre_q;
							upd        = 1'b1;
						end
					end
					REG_PRESC: begin
						psc_lim_n = PSC_W'(item.write_data);
					end
					REG_RELOAD: begin
						rld_pre_n = wr_cnt;
						if (!rld_buf_q) begin
							rld_act_n = wr_cnt;
						end
					end
					REG_COMPARE: begin
						cmp_pre_n = wr_cnt;
						if (!cmp_buf_q) begin
							cmp_act_n = wr_cnt;
						end
					end
					REG_COUNTER: begin
						main_cnt_n = wr_cnt;
					end
					default: begin
					end
				endcase
			end
			REQ_READ: begin
				unique case (item.reg_sel)
					REG_CTRL: begin
						rd_data[CTRL_RUN_BIT]  = run_q;
						rd_data[CTRL_RBUF_BIT] = rld_buf_q;
					end
					REG_MODE: begin
						rd_data[MODE_LSB +: MODE_W] = mode_q;
						rd_data[MODE_CBUF_BIT]      = cmp_buf_q;
					end
					REG_ENABLE: begin
						rd_data[EN_ON_BIT]  = on_q;
						rd_data[EN_POL_BIT] = pol_q;
					end
					REG_EVENT:   rd_data = '0;
					REG_PRESC:   rd_data = DATA_W'(psc_lim_q);
					REG_RELOAD:  rd_data = DATA_W'(rld_pre_q);
					REG_COMPARE: rd_data = DATA_W'(cmp_pre_q);
					REG_COUNTER: rd_data = DATA_W'(main_cnt_q);
					default:     rd_data = '0;
				endcase
			end
			REQ_DUTY: begin
				// New compare lands in both copies, then the update restarts counting
				cmp_pre_n  = duty_cmp;
				cmp_act_n  = duty_cmp;
				rld_act_n  = rld_pre_q;
				psc_cnt_n  = '0;
				main_cnt_n = '0;
				upd        = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign ref_level = (mode_n == MODE_PWM1) && (main_cnt_n < cmp_act_n);

	assign result.pwm_level    = on_n & (ref_level ^ pol_n);
	assign result.read_data    = rd_data;
	assign result.update_event = upd;

	// Forward the reload preload as it stands after this transaction
	assign reload_next = exec ? rld_pre_n : rld_pre_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			psc_cnt_q  <= '0;
			main_cnt_q <= '0;
			psc_lim_q  <= '0;
			rld_pre_q  <= '1;
			rld_act_q  <= '1;
			cmp_pre_q  <= '0;
			cmp_act_q  <= '0;
			run_q      <= 1'b0;
			rld_buf_q  <= 1'b0;
			mode_q     <= '0;
			cmp_buf_q  <= 1'b0;
			pol_q      <= 1'b0;
			on_q       <= 1'b0;
		end else if (exec) begin
			psc_cnt_q  <= psc_cnt_n;
			main_cnt_q <= main_cnt_n;
			psc_lim_q  <= psc_lim_n;
			rld_pre_q  <= rld_pre_n;
			rld_act_q  <= rld_act_n;
			cmp_pre_q  <= cmp_pre_n;
			cmp_act_q  <= cmp_act_n;
			run_q      <= run_n;
			rld_buf_q  <= rld_buf_n;
			mode_q     <= mode_n;
			cmp_buf_q  <= cmp_buf_n;
			pol_q      <= pol_n;
			on_q       <= on_n;
		end
	end

endmodule

>>> sv/pwm_timer_channel_unit.sv
// ----------------------------------------------------------------------------
// PWM timer channel unit
// Up-counting timer with prescaler, preloaded reload and compare, and one
// PWM mode 1 output, driven by a stream of tick and register transactions.
// ----------------------------------------------------------------------------
// Takes one transaction per clock and returns one result for each after
// acceptance, by way of an input register (which also forms the duty product
// (reload + 1) * percent) and the result register behind the single-pass
// timer logic. Throughput is one transaction per cycle, limited only by the
// timer state being read and updated once per transaction in that pass; the
// input stalls only while a finished result is held by a stalled receiver
// and the input register is already full.
module pwm_timer_channel_unit import ptc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  logic [1:0]        req_type,
	input  logic [2:0]        reg_sel,
	input  logic [DATA_W-1:0] write_data,
	input  logic [DUTY_W-1:0] duty_percent,
	output logic              result_valid,
	input  logic              result_stall,
	output logic              pwm_level,
	output logic [DATA_W-1:0] read_data,
	output logic              update_event
);

	logic              valid_s1;
	item_t             item_s1;
	item_t             item_d;
	logic              result_valid_q;
	result_t           result_q;
	result_t           result_d;
	logic              advance;
	logic              exec;
	logic              load;
	logic [CNT_W-1:0]  reload_next;
	logic [CNT_W:0]    reload_span;
	logic [PCT_W-1:0]  pct;

	assign advance    = !result_valid_q || !result_stall;
	assign exec       = valid_s1 && advance;
	assign item_stall = valid_s1 && !advance;
	assign load       = item_valid && !item_stall;

	// Clamp the duty to 100 % and form the product against the forwarded reload
	assign pct         = (duty_percent > DUTY_W'(PCT_MAX)) ? PCT_MAX : PCT_W'(duty_percent);
	assign reload_span = {1'b0, reload_next} + (CNT_W + 1)'(1);

	assign item_d.req_type   = req_type;
	assign item_d.reg_sel    = reg_sel;
	assign item_d.write_data = write_data;
	assign item_d.duty_prod  = PROD_W'(reload_span) * PROD_W'(pct);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= item_d;
		end
	end

	ptc_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.exec        (exec),
		.item        (item_s1),
		.result      (result_d),
		.reload_next (reload_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			result_q <= result_d;
		end
	end

	assign result_valid = result_valid_q;
	assign pwm_level    = result_q.pwm_level;
	assign read_data    = result_q.read_data;
	assign update_event = result_q.update_event;

endmodule

>>> sv/ptc_checker.sv
// ----------------------------------------------------------------------------
// PWM timer channel checker
// Port-level checks on the handshake behaviour of the timer channel unit.
// ----------------------------------------------------------------------------
`include "pwm_timer_channel_unit_assert.svh"

module ptc_checker import ptc_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              item_valid,
	input logic              item_stall,
	input logic [1:0]        req_type,
	input logic [2:0]        reg_sel,
	input logic [DATA_W-1:0] write_data,
	input logic [DUTY_W-1:0] duty_percent,
	input logic              result_valid,
	input logic              result_stall,
	input logic              pwm_level,
	input logic [DATA_W-1:0] read_data,
	input logic              update_event
);

	logic                           in_taken;
	logic                           in_held;
	logic                           out_held;
	logic [2+3+DATA_W+DUTY_W-1:0]   in_payload;
	logic [DATA_W+1:0]              out_payload;

	assign in_taken    = item_valid && !item_stall;
	assign in_held     = item_valid && item_stall;
	assign out_held    = result_valid && result_stall;
	assign in_payload  = {req_type, reg_sel, write_data, duty_percent};
	assign out_payload = {pwm_level, read_data, update_event};

	// Input back-pressure only ever comes from a held result
	`PTC_ASSERT_IMP(a_stall_from_output, item_stall, out_held, "stall without a held result")

	// Accepted transaction becomes a valid result past the input register when the result side is not stalled
	`PTC_ASSERT_NXT(a_two_cycle_latency, in_taken ##1 !result_stall, result_valid, "late result")

	`PTC_ASSERT_NXT(a_result_held, out_held, result_valid, "stalled result dropped")

	`PTC_ASSERT_NXT(a_payload_held, out_held, $stable(out_payload), "stalled result changed")

	// A stalled transaction waits unchanged on the input side
	`PTC_ASSERT_NXT(a_input_held, in_held, item_valid && $stable(in_payload), "stalled input changed")

endmodule

bind pwm_timer_channel_unit ptc_checker u_ptc_checker (.*);

>>> tb/sv/tb_pwm_timer_channel_unit.sv
// ----------------------------------------------------------------------------
// PWM timer channel unit testbench
// A short scripted sequence first: reset values, stopped timer, prescaler and
// reload wrap, duty clamp, buffered and direct reload/compare writes, event
// register and inactive output modes. Then random request streams weighted
// towards a running timer with small reload and prescaler values. Every
// result is checked against a fixed scripted value or the bench's timer
// predictor, with random request gaps and random result stalls.
// ----------------------------------------------------------------------------
module tb_pwm_timer_channel_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import ptc_pkg::*;

	localparam int unsigned RANDOM_REQUESTS = 750;
	localparam int unsigned IDLE_LIMIT      = 4000;
	localparam int unsigned REPORT_LIMIT    = 10;

	typedef struct {
		logic [1:0]        req;
		logic [2:0]        sel;
		logic [DATA_W-1:0] data;
		logic [DUTY_W-1:0] pct;
		bit                fixed;
		result_t           want;
	} request_row_t;

	logic              clk;
	logic              arst_n       = 1'b0;
	logic              item_valid   = 1'b0;
	logic              item_stall;
	logic [1:0]        req_type     = REQ_TICK;
	logic [2:0]        reg_sel      = REG_CTRL;
	logic [DATA_W-1:0] write_data   = '0;
	logic [DUTY_W-1:0] duty_percent = '0;
	logic              result_valid;
	logic              result_stall = 1'b0;
	logic              pwm_level;
	logic [DATA_W-1:0] read_data;
	logic              update_event;

	// Predicted timer state
	logic [PSC_W-1:0]  psc_cnt;
	logic [PSC_W-1:0]  psc_lim;
	logic [CNT_W-1:0]  ctr;
	logic [CNT_W-1:0]  arr_pre;
	logic [CNT_W-1:0]  arr_act;
	logic [CNT_W-1:0]  ccr_pre;
	logic [CNT_W-1:0]  ccr_act;
	logic              cen;
	logic              arpe;
	logic [MODE_W-1:0] oc_mode;
	logic              ocpe;
	logic              pol_low;
	logic              ch_on;

	result_t      expected_results[$];
	request_row_t script[$];

	bit          calm;
	int unsigned stall_left;
	int unsigned idle_cycles;
	int unsigned fault_count;
	int unsigned n_sent, n_ticks, n_reads, n_duty, n_checked, n_updates;

	pwm_timer_channel_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.req_type     (req_type),
		.reg_sel      (reg_sel),
		.write_data   (write_data),
		.duty_percent (duty_percent),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.pwm_level    (pwm_level),
		.read_data    (read_data),
		.update_event (update_event)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic void clear_timer();
		psc_cnt = '0;
		ctr     = '0;
		psc_lim = '0;
		arr_pre = '1;
		arr_act = '1;
		ccr_pre = '0;
		ccr_act = '0;
		cen     = 1'b0;
		arpe    = 1'b0;
		oc_mode = '0;
		ocpe    = 1'b0;
		pol_low = 1'b0;
		ch_on   = 1'b0;
	endfunction

	// Restart counting and move both shadows to their active copies
	function automatic void reload_shadows();
		psc_cnt = '0;
		ctr     = '0;
		arr_act = arr_pre;
		ccr_act = ccr_pre;
	endfunction

	function automatic result_t timer_step(input logic [1:0] req, input logic [2:0] sel,
			input logic [DATA_W-1:0] data, input logic [DUTY_W-1:0] pct);
		result_t          r;
		logic [DUTY_W-1:0] p;
		longint unsigned  prod;
		logic             oc_ref;
		r = '0;
		case (req)
		REQ_TICK: begin
			if (cen) begin
				if (psc_cnt < psc_lim) begin
					psc_cnt = psc_cnt + PSC_W'(1);
				end else if (ctr >= arr_act) begin
					reload_shadows();
					r.update_event = 1'b1;
				end else begin
					psc_cnt = '0;
					ctr     = ctr + CNT_W'(1);
				end
			end
		end
		REQ_WRITE: begin
			case (sel)
			REG_CTRL: begin
				cen  = data[CTRL_RUN_BIT];
				arpe = data[CTRL_RBUF_BIT];
			end
			REG_MODE: begin
				oc_mode = data[MODE_LSB +: MODE_W];
				ocpe    = data[MODE_CBUF_BIT];
			end
			REG_ENABLE: begin
				ch_on   = data[EN_ON_BIT];
				pol_low = data[EN_POL_BIT];
			end
			REG_EVENT: begin
				if (data[EVT_UPD_BIT]) begin
					reload_shadows();
					r.update_event = 1'b1;
				end
			end
			REG_PRESC: psc_lim = PSC_W'(data);
			REG_RELOAD: begin
				arr_pre = CNT_W'(data);
				if (!arpe)
					arr_act = arr_pre;
			end
			REG_COMPARE: begin
				ccr_pre = CNT_W'(data);
				if (!ocpe)
					ccr_act = ccr_pre;
			end
			default: ctr = CNT_W'(data);
			endcase
		end
		REQ_READ: begin
			case (sel)
			REG_CTRL: begin
				r.read_data[CTRL_RUN_BIT]  = cen;
				r.read_data[CTRL_RBUF_BIT] = arpe;
			end
			REG_MODE: begin
				r.read_data[MODE_LSB +: MODE_W] = oc_mode;
				r.read_data[MODE_CBUF_BIT]      = ocpe;
			end
			REG_ENABLE: begin
				r.read_data[EN_ON_BIT]  = ch_on;
				r.read_data[EN_POL_BIT] = pol_low;
			end
			REG_PRESC:   r.read_data = DATA_W'(psc_lim);
			REG_RELOAD:  r.read_data = DATA_W'(arr_pre);
			REG_COMPARE: r.read_data = DATA_W'(ccr_pre);
			REG_COUNTER: r.read_data = DATA_W'(ctr);
			default:     r.read_data = '0;
			endcase
		end
		default: begin
			// clamp to 100 %, then compare = (reload + 1) * pct / 100
			p    = (pct > PCT_MAX) ? DUTY_W'(PCT_MAX) : pct;
			prod = ((longint'(arr_pre) + 1) * longint'(p)) / 100;
			ccr_pre = CNT_W'(prod);
			if (!ocpe)
				ccr_act = ccr_pre;
			reload_shadows();
			r.update_event = 1'b1;
		end
		endcase
		oc_ref      = (oc_mode == MODE_PWM1) && (ctr < ccr_act);
		r.pwm_level = ch_on & (oc_ref ^ pol_low);
		return r;
	endfunction

	// Mostly back to back, some short pauses, a few long ones
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	function automatic void add_row(input logic [1:0] req, input logic [2:0] sel,
			input logic [DATA_W-1:0] data, input logic [DUTY_W-1:0] pct = '0,
			input bit fixed = 1'b0, input logic lvl = 1'b0,
			input logic [DATA_W-1:0] rd = '0, input logic upd = 1'b0);
		request_row_t row;
		row.req   = req;
		row.sel   = sel;
		row.data  = data;
		row.pct   = pct;
		row.fixed = fixed;
		row.want  = '{pwm_level: lvl, read_data: rd, update_event: upd};
		script.push_back(row);
	endfunction

	task automatic send_request(input request_row_t row);
		int unsigned gap;
		result_t     predicted;
		gap = pick_gap();
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid   <= 1'b1;
		req_type     <= row.req;
		reg_sel      <= row.sel;
		write_data   <= row.data;
		duty_percent <= row.pct;
		do @(posedge clk); while (item_stall);
		predicted = timer_step(row.req, row.sel, row.data, row.pct);
		expected_results.push_back(row.fixed ? row.want : predicted);
		n_sent++;
		case (row.req)
		REQ_TICK: n_ticks++;
		REQ_READ: n_reads++;
		REQ_DUTY: n_duty++;
		default: ;
		endcase
		// switch whole stretches to back-to-back traffic now and then
		if (n_sent % 96 == 0)
			calm = ($urandom_range(0, 3) == 0);
	endtask

	// Result side back-pressure
	always @(posedge clk) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else if (stall_left != 0) begin
			result_stall <= 1'b1;
			stall_left = stall_left - 1;
		end else begin
			result_stall <= 1'b0;
			stall_left = pick_gap();
		end
	end

	always @(posedge clk) begin : check_results
		result_t got;
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			got = '{pwm_level: pwm_level, read_data: read_data, update_event: update_event};
			n_checked++;
			if (got.update_event)
				n_updates++;
			if (expected_results.size() == 0) begin
				if (fault_count < REPORT_LIMIT)
					$display("[%0t] unexpected result: level=%0b data=%h update=%0b",
						$realtime, got.pwm_level, got.read_data, got.update_event);
				fault_count++;
			end else begin
				want = expected_results.pop_front();
				if (got.pwm_level !== want.pwm_level || got.read_data !== want.read_data
						|| got.update_event !== want.update_event) begin
					if (fault_count < REPORT_LIMIT)
						$display({"[%0t] result %0d: exp level=%0b data=%h update=%0b,",
							" got level=%0b data=%h update=%0b"},
							$realtime, n_checked, want.pwm_level, want.read_data,
							want.update_event, got.pwm_level, got.read_data,
							got.update_event);
					fault_count++;
				end
			end
		end
	end

	// Abort if nothing moves on either side for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (result_valid && !result_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("[%0t] no transaction for %0d cycles", $realtime, IDLE_LIMIT);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin
		request_row_t row;
		int unsigned  r;
		clear_timer();

		// reset values and a stopped timer
		add_row(REQ_READ,  REG_CTRL,    16'h0000, 8'd0, 1'b1, 1'b0, 16'h0000, 1'b0);
		add_row(REQ_READ,  REG_RELOAD,  16'h0000, 8'd0, 1'b1, 1'b0, 16'hFFFF, 1'b0);
		add_row(REQ_READ,  REG_EVENT,   16'hFFFF, 8'd0, 1'b1, 1'b0, 16'h0000, 1'b0);
		add_row(REQ_TICK,  REG_CTRL,    16'h0000, 8'd0, 1'b1, 1'b0, 16'h0000, 1'b0);
		add_row(REQ_WRITE, REG_EVENT,   16'hFFFE, 8'd0, 1'b1, 1'b0, 16'h0000, 1'b0);
		// inverted polarity, inactive mode: output sits at 1
		add_row(REQ_WRITE, REG_ENABLE,  16'h0003, 8'd0, 1'b1, 1'b1, 16'h0000, 1'b0);
		add_row(REQ_WRITE, REG_MODE,    16'h0060);
		add_row(REQ_WRITE, REG_ENABLE,  16'h0001);
		add_row(REQ_WRITE, REG_PRESC,   16'hFFFF);
		add_row(REQ_READ,  REG_PRESC,   16'h0000);
		add_row(REQ_WRITE, REG_PRESC,   16'h0000);
		add_row(REQ_WRITE, REG_RELOAD,  16'h0003);
		add_row(REQ_WRITE, REG_COMPARE, 16'h0002);
		add_row(REQ_WRITE, REG_CTRL,    16'h0081);
		repeat (4)
			add_row(REQ_TICK, REG_CTRL, 16'h0000);
		// duty above 100 clamps, then zero and half
		add_row(REQ_DUTY,  REG_CTRL,    16'h0000, 8'd255);
		add_row(REQ_DUTY,  REG_CTRL,    16'h0000, 8'd0);
		add_row(REQ_DUTY,  REG_CTRL,    16'h0000, 8'd50);
		// counter beyond reload wraps on the next advance
		add_row(REQ_WRITE, REG_COUNTER, 16'hFFFF);
		add_row(REQ_TICK,  REG_CTRL,    16'h0000);
		// reload of zero: every advance is an update
		add_row(REQ_WRITE, REG_RELOAD,  16'h0000);
		add_row(REQ_WRITE, REG_EVENT,   16'h0001);
		add_row(REQ_TICK,  REG_CTRL,    16'h0000);
		add_row(REQ_WRITE, REG_MODE,    16'hFFFF);
		add_row(REQ_WRITE, REG_CTRL,    16'h0000);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i])
			send_request(script[i]);

		for (int unsigned n = 0; n < RANDOM_REQUESTS; n++) begin
			row.fixed = 1'b0;
			row.want  = '0;
			row.sel   = 3'($urandom_range(0, 7));
			row.data  = DATA_W'($urandom_range(0, 65535));
			row.pct   = DUTY_W'($urandom_range(0, 255));
			r = $urandom_range(0, 99);
			if (r < 50)
				row.req = REQ_TICK;
			else if (r < 78)
				row.req = REQ_WRITE;
			else if (r < 90)
				row.req = REQ_READ;
			else
				row.req = REQ_DUTY;
			// keep the timer running with short periods most of the time
			if (row.req == REQ_WRITE) begin
				r = $urandom_range(0, 99);
				case (row.sel)
				REG_CTRL:   row.data[CTRL_RUN_BIT] = (r < 85);
				REG_MODE:   if (r < 75) row.data[MODE_LSB +: MODE_W] = MODE_PWM1;
				REG_ENABLE: row.data[EN_ON_BIT] = (r < 85);
				REG_PRESC:   if (r < 80) row.data = DATA_W'($urandom_range(0, 3));
				REG_RELOAD:  if (r < 80) row.data = DATA_W'($urandom_range(0, 20));
				REG_COMPARE: if (r < 80) row.data = DATA_W'($urandom_range(0, 24));
				REG_COUNTER: if (r < 70) row.data = DATA_W'($urandom_range(0, 20));
				default: ;
				endcase
			end
			send_request(row);
		end
		item_valid <= 1'b0;

		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Sent %0d requests: %0d ticks, %0d reads, %0d duty requests, rest writes.",
			n_sent, n_ticks, n_reads, n_duty);
		$display("Checked %0d results, %0d with an update event; %0d mismatches.",
			n_checked, n_updates, fault_count);
		if (fault_count == 0 && expected_results.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
